>>> sv/kt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kt_pkg;

    // request codes
    localparam logic [1:0] REQ_ARM   = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // result kinds
    localparam logic KIND_FIRED = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // most timers fired by one tick
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  timer_id;
        logic [23:0] timeout;
        logic        repeat_req;
    } req_t;

    typedef struct packed {
        logic       result_kind;
        logic [3:0] fired_id;
        logic       expired;
        logic       last;
    } rsp_t;

    // one timer slot as held in the table memory
    typedef struct packed {
        logic [31:0] deadline;
        logic [23:0] interval;
        logic        repeating;
    } entry_t;

    // result handed from the controller to the output register
    typedef struct packed {
        logic valid;
        rsp_t item;
    } rsp_push_t;

endpackage

`default_nettype wire

>>> sv/keyed_timer_table_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                    Direction  Contents
// -------   -------------------------  ---------  -------------------------------
// request   req_valid, req_stall, req  into block one item: arm, tick or query
// result    rsp_valid, rsp_stall, rsp  out        one item: fired id or query answer
//
// Arm is a single table write; a query reads the table, then waits for the output.
// A tick firing k timers runs k + 1 selection rounds: every selection round is
// one pass over the table memory's single read port, one slot per cycle, plus
// a decide step.
// Reset clears time, armed bits and control; table entries stay unwritten.
// A full output register stalls the sequencer only where it has a result to send.

module keyed_timer_table_top #(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire kt_pkg::req_t  req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output kt_pkg::rsp_t       rsp
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    kt_pkg::rsp_push_t  push;
    logic               out_free;
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    kt_pkg::entry_t     mem_wr_data;
    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_addr;
    kt_pkg::entry_t     mem_rd_data;

    // output register
    logic               rsp_valid_reg, rsp_valid_next;
    kt_pkg::rsp_t       rsp_reg, rsp_next;

    // deadline / interval / repeat per slot; armed bits live in the sequencer
    kt_mem #(
        .DEPTH (NUM_TIMERS),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    kt_ctrl #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .out_free    (out_free),
        .push        (push),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // register can take a new item when empty or being drained this cycle
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (push.valid)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = push.item;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> sv/kt_mem.sv
`timescale 1ns / 1ps
`default_nettype none

// Timer table: one write port, one read port, registered read data.
// Read data holds while no read is issued.
module kt_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire kt_pkg::entry_t    wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output kt_pkg::entry_t         rd_data
);

    kt_pkg::entry_t mem [DEPTH];
    kt_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> sv/kt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: arm writes, query reads, tick runs scan rounds over the table.
module kt_ctrl #(
    parameter int NUM_TIMERS = 16,
    parameter int IDX_W      = 4
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire kt_pkg::req_t                req,
    input  wire logic                        out_free,
    output kt_pkg::rsp_push_t                push,
    output logic                             mem_wr_en,
    output logic [IDX_W-1:0]                 mem_wr_addr,
    output kt_pkg::entry_t                   mem_wr_data,
    output logic                             mem_rd_en,
    output logic [IDX_W-1:0]                 mem_rd_addr,
    input  wire kt_pkg::entry_t              mem_rd_data
);

    localparam int CNT_W = $clog2(NUM_TIMERS + 1);
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
    localparam int RC_W  = kt_pkg::RES_CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QRY,
        ST_SCAN,
        ST_DECIDE,
        ST_FLUSH
    } state_t;

    state_t                 state_reg, state_next;
    logic [31:0]            now_reg, now_next;
    logic [NUM_TIMERS-1:0]  armed_reg, armed_next;
    logic [NUM_TIMERS-1:0]  pending_reg, pending_next;
    logic                   first_reg, first_next;
    logic [CNT_W-1:0]       scan_reg, scan_next;
    logic                   best_vld_reg, best_vld_next;
    logic [IDX_W-1:0]       best_id_reg, best_id_next;
    logic [31:0]            best_age_reg, best_age_next;
    logic [23:0]            best_int_reg, best_int_next;
    logic                   best_rep_reg, best_rep_next;
    logic                   held_vld_reg, held_vld_next;
    logic [3:0]             held_id_reg, held_id_next;
    logic [RC_W-1:0]        count_reg, count_next;
    logic [3:0]             qid_reg, qid_next;
    logic [IDX_W-1:0]       qidx_reg, qidx_next;
    logic                   qin_reg, qin_next;

    logic [CMP_W-1:0]       id_ext;
    logic                   id_in_range;
    logic [IDX_W-1:0]       id_idx;
    logic [CNT_W-1:0]       prev_scan;
    logic [IDX_W-1:0]       slot;
    logic [31:0]            age;
    logic                   cand;
    logic [CMP_W-1:0]       best_ext;

    assign id_ext      = CMP_W'(req.timer_id);
    assign id_in_range = id_ext < CMP_W'(NUM_TIMERS);
    assign id_idx      = id_ext[IDX_W-1:0];
    assign prev_scan   = scan_reg - CNT_W'(1);
    assign slot        = prev_scan[IDX_W-1:0];
    assign age         = now_reg - mem_rd_data.deadline;
    assign best_ext    = CMP_W'(best_id_reg);
    assign req_stall   = (state_reg != ST_IDLE);

    // first round takes the due set; later rounds only see what is left of it
    assign cand = first_reg ? (armed_reg[slot] && !age[31]) : pending_reg[slot];

    always_comb
    begin
        state_next    = state_reg;
        now_next      = now_reg;
        armed_next    = armed_reg;
        pending_next  = pending_reg;
        first_next    = first_reg;
        scan_next     = scan_reg;
        best_vld_next = best_vld_reg;
        best_id_next  = best_id_reg;
        best_age_next = best_age_reg;
        best_int_next = best_int_reg;
        best_rep_next = best_rep_reg;
        held_vld_next = held_vld_reg;
        held_id_next  = held_id_reg;
        count_next    = count_reg;
        qid_next      = qid_reg;
        qidx_next     = qidx_reg;
        qin_next      = qin_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = best_id_reg;
        mem_wr_data   = '0;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = id_idx;
        push          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req.req_type)
                        kt_pkg::REQ_ARM:
                        begin
                            if (id_in_range)
                            begin
                                mem_wr_en             = 1'b1;
                                mem_wr_addr           = id_idx;
                                mem_wr_data.deadline  = now_reg + 32'(req.timeout);
                                mem_wr_data.interval  = req.timeout;
                                mem_wr_data.repeating = req.repeat_req;
                                armed_next[id_idx]    = 1'b1;
                            end
                        end
                        kt_pkg::REQ_TICK:
                        begin
                            now_next      = now_reg + 32'd1;
                            first_next    = 1'b1;
                            scan_next     = '0;
                            best_vld_next = 1'b0;
                            held_vld_next = 1'b0;
                            count_next    = '0;
                            state_next    = ST_SCAN;
                        end
                        kt_pkg::REQ_QUERY:
                        begin
                            mem_rd_en  = id_in_range;
                            qid_next   = req.timer_id;
                            qidx_next  = id_idx;
                            qin_next   = id_in_range;
                            state_next = ST_QRY;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_QRY:
            begin
                if (out_free)
                begin
                    push.valid            = 1'b1;
                    push.item.result_kind = kt_pkg::KIND_QUERY;
                    push.item.fired_id    = qid_reg;
                    push.item.expired     = !(qin_reg && armed_reg[qidx_reg] && age[31]);
                    push.item.last        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                // issue read of slot scan_reg, evaluate slot scan_reg-1
                mem_rd_en   = (scan_reg < CNT_W'(NUM_TIMERS));
                mem_rd_addr = scan_reg[IDX_W-1:0];
                if (scan_reg != '0)
                begin
                    if (first_reg)
                    begin
                        pending_next[slot] = cand;
                    end
                    if (cand && (!best_vld_reg || age > best_age_reg))
                    begin
                        best_vld_next = 1'b1;
                        best_id_next  = slot;
                        best_age_next = age;
                        best_int_next = mem_rd_data.interval;
                        best_rep_next = mem_rd_data.repeating;
                    end
                end
                scan_next = scan_reg + CNT_W'(1);
                if (scan_reg == CNT_W'(NUM_TIMERS))
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (best_vld_reg && count_reg < RC_W'(kt_pkg::MAX_RESULTS))
                begin
                    // the held result is not the last one: send it now
                    if (!held_vld_reg || out_free)
                    begin
                        if (held_vld_reg)
                        begin
                            push.valid            = 1'b1;
                            push.item.result_kind = kt_pkg::KIND_FIRED;
                            push.item.fired_id    = held_id_reg;
                            push.item.expired     = 1'b0;
                            push.item.last        = 1'b0;
                        end
                        if (best_rep_reg)
                        begin
                            mem_wr_en             = 1'b1;
                            mem_wr_addr           = best_id_reg;
                            mem_wr_data.deadline  = now_reg + 32'(best_int_reg);
                            mem_wr_data.interval  = best_int_reg;
                            mem_wr_data.repeating = 1'b1;
                        end
                        else
                        begin
                            armed_next[best_id_reg] = 1'b0;
                        end
                        pending_next[best_id_reg] = 1'b0;
                        held_vld_next = 1'b1;
                        held_id_next  = best_ext[3:0];
                        count_next    = count_reg + RC_W'(1);
                        first_next    = 1'b0;
                        best_vld_next = 1'b0;
                        scan_next     = '0;
                        state_next    = ST_SCAN;
                    end
                end
                else
                begin
                    state_next = held_vld_reg ? ST_FLUSH : ST_IDLE;
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    push.valid            = 1'b1;
                    push.item.result_kind = kt_pkg::KIND_FIRED;
                    push.item.fired_id    = held_id_reg;
                    push.item.expired     = 1'b0;
                    push.item.last        = 1'b1;
                    held_vld_next         = 1'b0;
                    state_next            = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            now_reg      <= '0;
            armed_reg    <= '0;
            pending_reg  <= '0;
            first_reg    <= 1'b0;
            scan_reg     <= '0;
            best_vld_reg <= 1'b0;
            best_id_reg  <= '0;
            best_age_reg <= '0;
            best_int_reg <= '0;
            best_rep_reg <= 1'b0;
            held_vld_reg <= 1'b0;
            held_id_reg  <= '0;
            count_reg    <= '0;
            qid_reg      <= '0;
            qidx_reg     <= '0;
            qin_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            now_reg      <= now_next;
            armed_reg    <= armed_next;
            pending_reg  <= pending_next;
            first_reg    <= first_next;
            scan_reg     <= scan_next;
            best_vld_reg <= best_vld_next;
            best_id_reg  <= best_id_next;
            best_age_reg <= best_age_next;
            best_int_reg <= best_int_next;
            best_rep_reg <= best_rep_next;
            held_vld_reg <= held_vld_next;
            held_id_reg  <= held_id_next;
            count_reg    <= count_next;
            qid_reg      <= qid_next;
            qidx_reg     <= qidx_next;
            qin_reg      <= qin_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/kt_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module kt_chk (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         req_valid,
    input wire logic         req_stall,
    input wire kt_pkg::req_t req,
    input wire logic         rsp_valid,
    input wire logic         rsp_stall,
    input wire kt_pkg::rsp_t rsp
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    a_query_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.result_kind == kt_pkg::KIND_QUERY |-> rsp.last)
        else $error("query answer not marked last");

    a_fired_not_expired: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.result_kind == kt_pkg::KIND_FIRED |-> !rsp.expired)
        else $error("fired result carries expired flag");

    // arm leaves the block ready for the next request
    a_arm_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.req_type == kt_pkg::REQ_ARM |=> !req_stall)
        else $error("block busy after arm");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.req_type == kt_pkg::REQ_QUERY |=> req_stall)
        else $error("query did not hold off requests");

endmodule

bind keyed_timer_table_top kt_chk u_chk (.*);

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

// Bench for keyed_timer_table_top: request items come from a queue,
// result items are checked in order against a software copy of the timer table.
module tb;

    localparam int NUM_TIMERS = 16;
    // no meaning in the block; it must be dropped without a result
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // items left in the queue when both sides stop idling
    localparam int QUIET_TAIL = 40;
    // random items after the directed part
    localparam int RANDOM_ITEMS = 385;
    // cycles of silence after the last result
    localparam int DRAIN_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    kt_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    kt_pkg::rsp_t rsp;

    // requests waiting to go out, and answers the table is bound to give
    kt_pkg::req_t request_q[$];
    kt_pkg::rsp_t answer_q[$];

    // shadow timer table
    logic [31:0] t_now;
    logic [31:0] t_deadline [NUM_TIMERS];
    logic [23:0] t_interval [NUM_TIMERS];
    bit          t_armed [NUM_TIMERS];
    bit          t_repeat [NUM_TIMERS];

    int errors = 0;

    // request side idling: gap countdown, calm/busy phases
    int req_gap = 0;
    int req_phase = 0;
    bit req_calm = 1'b0;
    // result side stalling
    int rsp_gap = 0;
    int rsp_phase = 0;
    bit rsp_calm = 1'b0;

    keyed_timer_table_top #(
        .NUM_TIMERS(NUM_TIMERS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always #1 clk = ~clk;

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    function automatic void push_req(input logic [1:0] kind, input logic [3:0] id,
                                     input logic [23:0] tmo, input logic rep);
        kt_pkg::req_t r;
        r.req_type = kind;
        r.timer_id = id;
        r.timeout = tmo;
        r.repeat_req = rep;
        request_q.push_back(r);
    endfunction

    // Apply one accepted request to the shadow table and queue the answers it causes.
    task automatic table_step(input kt_pkg::req_t r);
        bit           pend [NUM_TIMERS];
        logic [31:0]  age;
        logic [31:0]  best_age;
        int           best;
        int           fired;
        kt_pkg::rsp_t ans;
        fired = 0;
        best_age = '0;
        case (r.req_type)
            kt_pkg::REQ_ARM:
            begin
                t_deadline[r.timer_id] = t_now + {8'd0, r.timeout};
                t_interval[r.timer_id] = r.timeout;
                t_repeat[r.timer_id] = r.repeat_req;
                t_armed[r.timer_id] = 1'b1;
            end
            kt_pkg::REQ_QUERY:
            begin
                ans.result_kind = kt_pkg::KIND_QUERY;
                ans.fired_id = r.timer_id;
                // reached when the signed distance now - deadline is not negative
                ans.expired = !t_armed[r.timer_id]
                              || !((t_now - t_deadline[r.timer_id]) >> 31);
                ans.last = 1'b1;
                answer_q.push_back(ans);
            end
            kt_pkg::REQ_TICK:
            begin
                t_now = t_now + 32'd1;
                // due set is frozen before firing: a zero-interval repeat fires once
                for (int s = 0; s < NUM_TIMERS; s++)
                    pend[s] = t_armed[s] && !((t_now - t_deadline[s]) >> 31);
                while (fired < kt_pkg::MAX_RESULTS)
                begin
                    best = -1;
                    // oldest deadline first; strict compare keeps the lower id on ties
                    for (int s = 0; s < NUM_TIMERS; s++)
                    begin
                        age = t_now - t_deadline[s];
                        if (pend[s] && (best < 0 || age > best_age))
                        begin
                            best = s;
                            best_age = age;
                        end
                    end
                    if (best < 0)
                        break;
                    pend[best] = 1'b0;
                    if (t_repeat[best])
                        t_deadline[best] = t_now + {8'd0, t_interval[best]};
                    else
                        t_armed[best] = 1'b0;
                    ans.result_kind = kt_pkg::KIND_FIRED;
                    ans.fired_id = 4'(best);
                    ans.expired = 1'b0;
                    ans.last = 1'b0;
                    answer_q.push_back(ans);
                    fired++;
                end
                if (fired > 0)
                    answer_q[answer_q.size() - 1].last = 1'b1;
            end
            default:
            begin
            end
        endcase
    endtask

    // Request driver: predicts on acceptance, then loads the next item or idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                table_step(req);
            if (req_phase == 0)
            begin
                req_phase = $urandom_range(16, 96);
                req_calm = $urandom_range(0, 1);
            end
            else
                req_phase--;
            // a stalled item stays put; otherwise the slot is free after this edge
            if (!req_valid || !req_stall)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_valid <= 1'b0;
                end
                else if (request_q.size() > QUIET_TAIL && !req_calm
                         && $urandom_range(0, 3) == 0)
                begin
                    req_gap = $urandom_range(1, 5) - 1;
                    req_valid <= 1'b0;
                end
                else if (request_q.size() != 0)
                begin
                    req <= request_q.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each accepted item against the oldest answer,
    // and drives stall in random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (answer_q.size() == 0)
                    flag_error($sformatf({"result with nothing pending:",
                                          " kind %0d id %0d exp %0d last %0d"},
                                         rsp.result_kind, rsp.fired_id, rsp.expired,
                                         rsp.last));
                else
                begin
                    automatic kt_pkg::rsp_t want = answer_q.pop_front();
                    if (rsp.result_kind !== want.result_kind || rsp.fired_id !== want.fired_id
                        || rsp.expired !== want.expired || rsp.last !== want.last)
                        flag_error($sformatf({"result mismatch: expected kind %0d id %0d exp %0d",
                                              " last %0d, got kind %0d id %0d exp %0d last %0d"},
                                             want.result_kind, want.fired_id, want.expired,
                                             want.last, rsp.result_kind, rsp.fired_id,
                                             rsp.expired, rsp.last));
                end
            end
            if (rsp_phase == 0)
            begin
                rsp_phase = $urandom_range(16, 96);
                rsp_calm = $urandom_range(0, 1);
            end
            else
                rsp_phase--;
            if (rsp_gap > 0)
            begin
                rsp_gap--;
                rsp_stall <= 1'b1;
            end
            else if (request_q.size() > QUIET_TAIL && !rsp_calm && $urandom_range(0, 3) == 0)
            begin
                rsp_gap = $urandom_range(1, 5) - 1;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        automatic int          acted = 0;
        automatic int          pick;
        automatic int          sel;
        automatic logic [1:0]  kind;
        automatic logic [23:0] tmo;

        t_now = '0;
        for (int s = 0; s < NUM_TIMERS; s++)
        begin
            t_armed[s] = 1'b0;
            t_repeat[s] = 1'b0;
        end

        // Directed part.
        push_req(kt_pkg::REQ_QUERY, 4'd0, 24'd0, 1'b0);          // unarmed: expired
        push_req(kt_pkg::REQ_ARM, 4'd15, 24'hFF_FFFF, 1'b1);     // longest timeout
        push_req(kt_pkg::REQ_QUERY, 4'd15, 24'd0, 1'b0);         // armed, far away
        push_req(kt_pkg::REQ_ARM, 4'd0, 24'd0, 1'b1);            // zero-interval repeat
        push_req(kt_pkg::REQ_QUERY, 4'd0, 24'hFF_FFFF, 1'b1);    // deadline already reached
        push_req(kt_pkg::REQ_TICK, 4'd3, 24'd5, 1'b1);           // fires id 0 once
        push_req(kt_pkg::REQ_TICK, 4'd0, 24'd0, 1'b0);           // and once more
        push_req(REQ_UNUSED, 4'd7, 24'hA5_5A5A, 1'b1);           // dropped
        push_req(kt_pkg::REQ_ARM, 4'd0, 24'd0, 1'b0);            // overwrite as one-shot
        // every slot due on the same tick: id 9 is oldest, the rest tie by id
        for (int i = 0; i < NUM_TIMERS; i++)
            push_req(kt_pkg::REQ_ARM, 4'(i), (i == 9) ? 24'd0 : 24'd1, 1'(i & 1));
        push_req(kt_pkg::REQ_TICK, 4'd0, 24'd0, 1'b0);
        push_req(kt_pkg::REQ_TICK, 4'd0, 24'd0, 1'b0);

        // Random part: mostly short timeouts so timers keep firing.
        while (acted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                kind = kt_pkg::REQ_ARM;
            else if (pick < 75)
                kind = kt_pkg::REQ_TICK;
            else if (pick < 95)
                kind = kt_pkg::REQ_QUERY;
            else
                kind = REQ_UNUSED;
            sel = $urandom_range(0, 19);
            if (sel < 16)
                tmo = 24'($urandom_range(0, 8));
            else if (sel < 18)
                tmo = 24'($urandom_range(0, 64));
            else
                tmo = 24'($urandom());
            push_req(kind, 4'($urandom_range(0, NUM_TIMERS - 1)), tmo, 1'($urandom_range(0, 1)));
            acted++;
        end

        repeat (5) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (request_q.size() != 0 || req_valid)
            @(posedge clk);
        while (answer_q.size() != 0)
            @(posedge clk);
        // catch anything extra the block still sends
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #1_500_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
